// ===== rtl/sliding_window_event_rate_meter_macros.svh =====
// Assertion macros for the sliding window event rate meter
`ifndef SLIDING_WINDOW_EVENT_RATE_METER_MACROS_SVH
`define SLIDING_WINDOW_EVENT_RATE_METER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SWERM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SWERM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/swerm_pkg.sv =====
// Shared constants and types for the sliding window event rate meter
package swerm_pkg;

	localparam int HISTORY_DEPTH = 128;
	localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
	localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
	localparam int STAMP_W       = 32;
	localparam int TPS_W         = 32;
	localparam int WIN_W         = 31;
	localparam int RATE_W        = 24;
	localparam int HELD_W        = 8;
	localparam int FRAC_W        = 8;
	localparam int NUM_W         = CNT_W + TPS_W;
	localparam int DVD_W         = NUM_W + FRAC_W;
	localparam int DIV_CNT_W     = $clog2(DVD_W);

	localparam logic [RATE_W-1:0] RATE_MAX = '1;

	// register index, taken from paddr[2]
	localparam logic REG_TPS = 1'b0;
	localparam logic REG_WIN = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/swerm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle
module swerm_div
	import swerm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DVD_W-1:0]   dividend,
	input  logic [STAMP_W-1:0] divisor,
	output div_stat_t          stat,
	output logic [DVD_W-1:0]   quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [STAMP_W-1:0]   rem_q;
	logic [STAMP_W-1:0]   dsr_q;
	logic [DVD_W-1:0]     quo_q;

	logic [STAMP_W:0]     trial;
	logic [STAMP_W:0]     diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[STAMP_W-1:0] : trial[STAMP_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ===== rtl/sliding_window_event_rate_meter.sv =====
// Steps: ST_EV_WAIT and ST_EV_CHK, repeated once per evicted stamp, then ST_BOUND,
// ST_APPEND, ST_FIRST_RD, ST_SPAN and, unless no division is needed, ST_START and the
// 48-step serial divider, which sets most of the latency; ready again once the result
// is in the output register, so a held result stalls the input.
// Reset: ring empty, ticks_per_second and window_ticks 1000000; stamp memory not cleared.
module sliding_window_event_rate_meter
	import swerm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] event_time
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [23:0] rate_q8, [31:24] events_held
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EV_WAIT,
		ST_EV_CHK,
		ST_BOUND,
		ST_APPEND,
		ST_FIRST_RD,
		ST_SPAN,
		ST_START,
		ST_DIV,
		ST_RESULT
	} state_t;

	state_t             state_q;
	logic [TPS_W-1:0]   tps_q;
	logic [WIN_W-1:0]   win_q;
	logic [SLOT_W-1:0]  oldest_q;
	logic [CNT_W-1:0]   held_q;
	logic [STAMP_W-1:0] now_q;
	logic [STAMP_W-1:0] rdata_q;
	logic [STAMP_W-1:0] span_q;
	logic [NUM_W-1:0]   num_q;
	logic [RATE_W-1:0]  rate_q;
	logic               m_valid_q;
	logic [RATE_W-1:0]  m_rate_q;
	logic [HELD_W-1:0]  m_held_q;

	logic [STAMP_W-1:0] ring [HISTORY_DEPTH];

	logic               cfg_wr;
	logic [STAMP_W-1:0] diff;
	logic               out_free;
	logic [SLOT_W-1:0]  oldest_nx;
	logic [SLOT_W:0]    wr_sum;
	logic [SLOT_W-1:0]  wr_addr;
	logic               wr_en;
	logic               div_start;
	div_stat_t          div_stat;
	logic [DVD_W-1:0]   div_quo;
	logic [HELD_W-1:0]  held_sat;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		unique case (paddr[2])
			REG_TPS: prdata = tps_q;
			REG_WIN: prdata = {1'b0, win_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_W'(1000000);
			win_q <= WIN_W'(1000000);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_TPS: tps_q <= pwdata;
				REG_WIN: win_q <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// shared subtractor: age during eviction, span after append
	assign diff     = now_q - rdata_q;
	assign out_free = !m_valid_q || m_axis_tready;

	assign oldest_nx = (oldest_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
	assign wr_sum    = {1'b0, oldest_q} + {1'b0, held_q[SLOT_W-1:0]};
	assign wr_addr   = (wr_sum >= (SLOT_W + 1)'(HISTORY_DEPTH))
		? SLOT_W'(wr_sum - (SLOT_W + 1)'(HISTORY_DEPTH)) : wr_sum[SLOT_W-1:0];
	assign wr_en     = (state_q == ST_APPEND);
	assign div_start = (state_q == ST_START);

	always_ff @(posedge clk) begin
		if (wr_en)
			ring[wr_addr] <= now_q;
		rdata_q <= ring[oldest_q];
	end

	swerm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({num_q, FRAC_W'(0)}),
		.divisor  (span_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign held_sat = (held_q > CNT_W'(255)) ? HELD_W'(255) : HELD_W'(held_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			oldest_q  <= '0;
			held_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESULT && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						now_q   <= s_axis_tdata;
						state_q <= ST_EV_WAIT;
					end
				end
				ST_EV_WAIT: state_q <= ST_EV_CHK;
				ST_EV_CHK: begin
					if (held_q != '0 && diff > {1'b0, win_q}) begin
						oldest_q <= oldest_nx;
						held_q   <= held_q - 1'b1;
						state_q  <= ST_EV_WAIT;
					end else begin
						state_q <= ST_BOUND;
					end
				end
				ST_BOUND: begin
					if (held_q >= CNT_W'(HISTORY_DEPTH)) begin
						oldest_q <= oldest_nx;
						held_q   <= held_q - 1'b1;
					end
					state_q <= ST_APPEND;
				end
				ST_APPEND: begin
					held_q  <= held_q + 1'b1;
					state_q <= ST_FIRST_RD;
				end
				ST_FIRST_RD: state_q <= ST_SPAN;
				ST_SPAN: begin
					if (held_q >= CNT_W'(2) && diff != '0) begin
						num_q   <= NUM_W'(held_q - 1'b1) * NUM_W'(tps_q);
						span_q  <= diff;
						state_q <= ST_START;
					end else begin
						rate_q  <= '0;
						state_q <= ST_RESULT;
					end
				end
				ST_START: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_stat.done) begin
						rate_q  <= (|div_quo[DVD_W-1:RATE_W]) ? RATE_MAX : div_quo[RATE_W-1:0];
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						m_rate_q  <= rate_q;
						m_held_q  <= held_sat;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {m_held_q, m_rate_q};

`include "sliding_window_event_rate_meter_macros.svh"

	`SWERM_ASSERT_NOW(a_held_bound, 1'b1, held_q <= CNT_W'(HISTORY_DEPTH), "held above depth")
	`SWERM_ASSERT_NOW(a_div_busy, state_q == ST_DIV && !div_stat.done, div_stat.busy, "div idle")
	`SWERM_ASSERT_NOW(a_div_done_state, div_stat.done, state_q == ST_DIV, "stray div done")
	`SWERM_ASSERT_NOW(a_result_nonempty, m_axis_tvalid, m_axis_tdata[31:24] != 8'd0, "empty")
	`SWERM_ASSERT_NEXT(a_append_grows, wr_en, held_q == $past(held_q) + 1'b1, "no growth")

endmodule

// ===== test/sliding_window_event_rate_meter_test.sv =====
// Self-checking testbench: event stream with APB setup, scoreboard against a rate predictor
`timescale 1ns / 100ps

module sliding_window_event_rate_meter_test;
	import swerm_pkg::*;

	localparam logic [2:0] TPS_ADDR = {REG_TPS, 2'b00};
	localparam logic [2:0] WIN_ADDR = {REG_WIN, 2'b00};
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 400;
	localparam int LONG_HOLD = 300;
	localparam int PRINT_LIMIT = 20;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic [HELD_W-1:0] held;
	} meter_reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // [31:0] event_time
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;  // [23:0] rate_q8, [31:24] events_held
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	sliding_window_event_rate_meter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [STAMP_W-1:0] stamp_copy [HISTORY_DEPTH];
	logic [SLOT_W-1:0] oldest_copy = '0;
	int unsigned held_copy = 0;
	logic [TPS_W-1:0] tps_setting = 32'd1000000;
	logic [WIN_W-1:0] window_setting = 31'd1000000;

	logic [STAMP_W-1:0] pending_stamps [$];
	meter_reading_t pending_readings [$];
	logic [31:0] stamp_cursor = '0;
	int unsigned stamps_offered = 0;
	int unsigned stamps_sent = 0;
	int unsigned readings_seen = 0;
	int unsigned settings_used = 0;
	int unsigned mismatch_count = 0;
	bit stamp_sent = 1'b0;
	bit any_transfer = 1'b0;
	bit idling_on = 1'b1;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
	endtask

	function automatic meter_reading_t tally_event(input logic [STAMP_W-1:0] now);
		logic [STAMP_W-1:0] age;
		logic [STAMP_W-1:0] span;
		logic [SLOT_W-1:0] slot;
		logic [63:0] num;
		logic [63:0] quo;
		meter_reading_t r;
		r.rate = '0;
		while (held_copy > 0) begin
			age = now - stamp_copy[oldest_copy];
			if (age <= {1'b0, window_setting})
				break;
			oldest_copy++;
			held_copy--;
		end
		if (held_copy >= HISTORY_DEPTH) begin
			oldest_copy++;
			held_copy--;
		end
		slot = oldest_copy + SLOT_W'(held_copy);
		stamp_copy[slot] = now;
		held_copy++;
		if (held_copy >= 2) begin
			span = now - stamp_copy[oldest_copy];
			if (span != 0) begin
				num = 64'(held_copy - 1) * 64'(tps_setting);
				quo = (num << FRAC_W) / 64'(span);
				r.rate = (quo > 64'(RATE_MAX)) ? RATE_MAX : quo[RATE_W-1:0];
			end
		end
		r.held = (held_copy > 255) ? 8'd255 : HELD_W'(held_copy);
		return r;
	endfunction

	// input side
	always @(negedge clk) begin
		if (arst_n) begin
			if (stamp_sent || !s_axis_tvalid) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_stamps.size() > 0) begin
					s_axis_tdata <= pending_stamps[0];
					pending_stamps.delete(0);
					s_axis_tvalid <= 1'b1;
					if (idling_on && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 5);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (idling_on && $urandom_range(0, 7) == 0)
					recv_gap = $urandom_range(1, 5);
			end
		end
	end

	// scoreboard: check the result first, then log the new event
	always @(posedge clk) begin
		meter_reading_t got;
		meter_reading_t want;
		if (arst_n) begin
			any_transfer = 1'b0;
			if (m_axis_tvalid && m_axis_tready) begin
				any_transfer = 1'b1;
				readings_seen++;
				got.rate = m_axis_tdata[23:0];
				got.held = m_axis_tdata[31:24];
				if (pending_readings.size() == 0) begin
					report_mismatch("reading with no event waiting", m_axis_tdata, 0);
				end else begin
					want = pending_readings[0];
					pending_readings.delete(0);
					if (got.rate !== want.rate)
						report_mismatch("rate_q8", got.rate, want.rate);
					if (got.held !== want.held)
						report_mismatch("events_held", got.held, want.held);
				end
			end
			stamp_sent = s_axis_tvalid && s_axis_tready;
			if (stamp_sent) begin
				any_transfer = 1'b1;
				stamps_sent++;
				pending_readings.insert(pending_readings.size(), tally_event(s_axis_tdata));
			end
		end
	end

	always @(negedge clk) begin
		if (any_transfer || (stamps_offered == stamps_sent && pending_readings.size() == 0))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == TPS_ADDR)
			tps_setting = data;
		else
			window_setting = data[WIN_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_check(input logic [2:0] addr);
		logic [31:0] seen;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		seen = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == TPS_ADDR) begin
			if (seen !== tps_setting)
				report_mismatch("ticks_per_second readback", seen, tps_setting);
		end else if (seen[WIN_W-1:0] !== window_setting) begin
			report_mismatch("window_ticks readback", seen[WIN_W-1:0], window_setting);
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (stamps_offered != stamps_sent || pending_readings.size() != 0);
	endtask

	task automatic configure(input logic [31:0] tps, input logic [31:0] win);
		wait_drained();
		apb_write(TPS_ADDR, tps);
		apb_write(WIN_ADDR, win);
		apb_check(TPS_ADDR);
		apb_check(WIN_ADDR);
		settings_used++;
		@(posedge clk);
	endtask

	task automatic queue_stamp(input logic [31:0] stamp);
		pending_stamps.insert(pending_stamps.size(), stamp);
		stamps_offered++;
		stamp_cursor = stamp;
	endtask

	// mostly advancing stamps; some repeats, window jumps, backward steps and noise
	task automatic queue_events(input int count, input logic [31:0] step_max);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 72)
				stamp_cursor = stamp_cursor + 32'($urandom_range(0, step_max));
			else if (pick < 80)
				stamp_cursor = stamp_cursor;
			else if (pick < 86)
				stamp_cursor = stamp_cursor + {1'b0, window_setting} +
					32'($urandom_range(1, step_max));
			else if (pick < 92)
				stamp_cursor = stamp_cursor - 32'($urandom_range(1, step_max));
			else
				stamp_cursor = $urandom();
			queue_stamp(stamp_cursor);
		end
	endtask

	task automatic run_phase(input logic [31:0] tps, input logic [31:0] win, input int count,
			input logic [31:0] step_max, input bit idle_mode, input bit long_hold);
		configure(tps, win);
		idling_on = idle_mode;
		stamp_cursor = $urandom();
		queue_events(count / 2, step_max);
		if (long_hold)
			hold_cycles = LONG_HOLD;
		// sender pause: let every result come back before the second half
		wait_drained();
		@(posedge clk);
		queue_events(count - count / 2, step_max);
	endtask

	initial begin
		logic [31:0] win;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values, then directed events at reset settings
		apb_check(TPS_ADDR);
		apb_check(WIN_ADDR);
		@(posedge clk);
		queue_stamp(32'h0000_0000);
		queue_stamp(32'h0000_0000);
		queue_stamp(32'h0000_0001);
		queue_stamp(32'd1000000);
		queue_stamp(32'd1000001);
		queue_stamp(32'hFFFF_FFFF);
		queue_stamp(32'h0000_0010);
		queue_stamp(32'h8000_0000);
		queue_stamp(32'h7FFF_FF00);

		// one-tick window: age equal to the window stays, one more is evicted
		configure(32'd1, 32'd1);
		queue_stamp(32'd10);
		queue_stamp(32'd11);
		queue_stamp(32'd12);
		queue_stamp(32'd12);
		queue_stamp(32'd14);

		// widest settings: saturation and the window edge at full size
		configure(32'hFFFF_FFFF, 32'h7FFF_FFFF);
		queue_stamp(32'h0000_0000);
		queue_stamp(32'h0000_0001);
		queue_stamp(32'h7FFF_FFFF);
		queue_stamp(32'h8000_0000);

		// zero settings
		configure(32'd0, 32'd0);
		queue_stamp(32'd100);
		queue_stamp(32'd100);
		queue_stamp(32'd101);
		queue_stamp(32'd101);

		run_phase(32'd1000000, 32'd1000000, 300, 32'd15000, 1'b1, 1'b1);
		run_phase(32'd1, 32'd1, 150, 32'd2, 1'b1, 1'b0);
		run_phase(32'hFFFF_FFFF, 32'h7FFF_FFFF, 250, 32'h0100_0000, 1'b1, 1'b0);
		run_phase(32'd0, 32'd1000, 60, 32'd50, 1'b1, 1'b0);
		for (int k = 0; k < 4; k++) begin
			win = $urandom_range(1, 32'h7FFF_FFFF);
			run_phase($urandom(), win, 250, (win >> $urandom_range(3, 9)) + 1, 1'b1, 1'b0);
		end
		run_phase(32'd25000, 32'd50000, 300, 32'd800, 1'b0, 1'b0);

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_readings.size() != 0)
			report_mismatch("readings never delivered", 0, pending_readings.size());
		$display("covered %0d events and %0d readings over %0d register settings",
			stamps_sent, readings_seen, settings_used);
		$display("including full ring, window edges, wrap, out-of-order stamps, %0d mismatches",
			mismatch_count);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
